/* rtl/imu_angle_packet_to_ascii_assert.svh */
// Assertion macros shared by the angle packet to ASCII block.
`ifndef IMU_ANGLE_PACKET_TO_ASCII_ASSERT_SVH
`define IMU_ANGLE_PACKET_TO_ASCII_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define APTA_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define APTA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`else

`define APTA_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define APTA_ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

/* rtl/apta_pkg.sv */
// Package: types and constants of the angle packet to ASCII block.
`default_nettype none

package apta_pkg;

	localparam int PACKET_LENGTH_DEF = 11;
	localparam int QUEUE_DEPTH_DEF   = 2;

	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int RAW_W     = 16;
	localparam int M_W       = 18;
	localparam int BCD_W     = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE = 2'd1;

	localparam logic [7:0] SYNC_RESET = 8'h55;
	localparam logic [7:0] TYPE_RESET = 8'h53;

	localparam logic [RAW_W-1:0] RAW_HALF = 16'h8000;
	localparam logic [12:0]      SCALE    = 13'd5625;

	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_POINT = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one shift-add-3 step of binary to BCD conversion
	function automatic logic [BCD_W-1:0] bcd_step(input logic [BCD_W-1:0] bcd,
			input logic in_bit);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int d = 0; d < BCD_W / 4; d++) begin
			if (adj[d*4 +: 4] >= 4'd5)
				adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
		end
		return {adj[BCD_W-2:0], in_bit};
	endfunction

endpackage

`default_nettype wire

/* rtl/apta_parser.sv */
// Front end: packet framing, checksum and type check, config registers.
`default_nettype none

module apta_parser #(
	parameter int PACKET_LENGTH = apta_pkg::PACKET_LENGTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire apta_pkg::cfg_wr_t           cfg,
	input  wire logic                        accept,
	input  wire logic [7:0]                  rx_byte,
	output logic                             push,
	output logic [apta_pkg::RAW_W-1:0]       push_raw
);

	localparam logic [apta_pkg::IDX_W:0] LAST_POS = (apta_pkg::IDX_W+1)'(PACKET_LENGTH);

	logic [7:0]                 sync_q, type_q;
	logic [apta_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                 sum_q, kind_q, low_q, high_q;

	logic [7:0] kind_n, low_n, high_n;
	logic       is_sync, at_end, good;

	always_comb begin
		is_sync = (rx_byte == sync_q);
		kind_n  = (idx_q == 4'd1) ? rx_byte : kind_q;
		low_n   = (idx_q == 4'd4) ? rx_byte : low_q;
		high_n  = (idx_q == 4'd5) ? rx_byte : high_q;
		at_end  = ({1'b0, idx_q} + 5'd1) >= LAST_POS;
		good    = (sum_q == rx_byte) && (kind_n == type_q);
	end

	assign push     = accept && !is_sync && at_end && good;
	assign push_raw = {high_n, low_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= apta_pkg::SYNC_RESET;
			type_q <= apta_pkg::TYPE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				apta_pkg::REG_SYNC: sync_q <= cfg.data;
				apta_pkg::REG_TYPE: type_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			sum_q  <= '0;
			kind_q <= '0;
			low_q  <= '0;
			high_q <= '0;
		end else if (accept) begin
			if (is_sync) begin
				idx_q  <= 4'd1;
				sum_q  <= rx_byte;
				kind_q <= '0;
				low_q  <= '0;
				high_q <= '0;
			end else begin
				kind_q <= kind_n;
				low_q  <= low_n;
				high_q <= high_n;
				if (at_end) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= idx_q + 4'd1;
					sum_q <= sum_q + rx_byte;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/apta_queue.sv */
// Short queue of raw angle values between the front and back ends.
`default_nettype none
`include "imu_angle_packet_to_ascii_assert.svh"

module apta_queue #(
	parameter int DEPTH = apta_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [apta_pkg::RAW_W-1:0]  push_raw,
	input  wire logic                        pop,
	output logic [apta_pkg::RAW_W-1:0]       pop_raw,
	output apta_pkg::q_stat_t                stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [apta_pkg::RAW_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]           wr_q, rd_q;
	logic [CNT_W-1:0]           cnt_q;

	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign pop_raw    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`APTA_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !stat.full)
	`APTA_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, !stat.empty)

endmodule

`default_nettype wire

/* rtl/apta_format.sv */
// Back end: scale to millidegrees, convert to decimal, emit the ASCII line.
`default_nettype none
`include "imu_angle_packet_to_ascii_assert.svh"

module apta_format (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire apta_pkg::q_stat_t           stat,
	input  wire logic [apta_pkg::RAW_W-1:0]  pop_raw,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       out_byte,
	output logic                             last_byte
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_CONV = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam int          PROD_W    = apta_pkg::RAW_W + 13;
	localparam logic [3:0]  CONV_LAST = 4'(apta_pkg::M_W / 2 - 1);
	localparam logic [3:0]  CHAR_LAST = 4'd9;

	logic [1:0]                 state_q;
	logic                       neg_q;
	logic [apta_pkg::RAW_W-1:0] mag_q;
	logic [apta_pkg::M_W-1:0]   m_q;
	logic [apta_pkg::BCD_W-1:0] bcd_q;
	logic [3:0]                 cnt_q;
	logic [3:0]                 char_q;
	logic                       out_valid_q, last_q;
	logic [7:0]                 out_byte_q;

	logic [PROD_W-1:0]          prod;
	logic                       out_free;
	logic [7:0]                 ch;

	assign pop      = (state_q == ST_IDLE) && !stat.empty;
	assign prod     = PROD_W'(mag_q) * PROD_W'(apta_pkg::SCALE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (char_q)
			4'd0:    ch = neg_q ? apta_pkg::CH_MINUS : apta_pkg::CH_PLUS;
			4'd1:    ch = apta_pkg::CH_ZERO + {4'd0, bcd_q[23:20]};
			4'd2:    ch = apta_pkg::CH_ZERO + {4'd0, bcd_q[19:16]};
			4'd3:    ch = apta_pkg::CH_ZERO + {4'd0, bcd_q[15:12]};
			4'd4:    ch = apta_pkg::CH_POINT;
			4'd5:    ch = apta_pkg::CH_ZERO + {4'd0, bcd_q[11:8]};
			4'd6:    ch = apta_pkg::CH_ZERO + {4'd0, bcd_q[7:4]};
			4'd7:    ch = apta_pkg::CH_ZERO + {4'd0, bcd_q[3:0]};
			4'd8:    ch = apta_pkg::CH_CR;
			default: ch = apta_pkg::CH_LF;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				neg_q <= (pop_raw > apta_pkg::RAW_HALF);
				mag_q <= (pop_raw > apta_pkg::RAW_HALF) ? 16'd0 - pop_raw : pop_raw;
			end
			ST_MUL: begin
				m_q   <= prod[apta_pkg::M_W+9:10];
				bcd_q <= '0;
			end
			ST_CONV: begin
				bcd_q <= apta_pkg::bcd_step(apta_pkg::bcd_step(bcd_q,
						m_q[apta_pkg::M_W-1]), m_q[apta_pkg::M_W-2]);
				m_q   <= {m_q[apta_pkg::M_W-3:0], 2'b00};
			end
			default: ;
		endcase
		if (out_free && state_q == ST_EMIT) begin
			out_byte_q <= ch;
			last_q     <= (char_q == CHAR_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			char_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (pop) state_q <= ST_MUL;
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == CONV_LAST) begin
						char_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: if (out_free) begin
					char_q <= char_q + 4'd1;
					if (char_q == CHAR_LAST)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_free)
				out_valid_q <= (state_q == ST_EMIT);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	`APTA_ASSERT_IMPLY(a_last_is_lf, clk, arst_n, out_valid_q && last_q,
		out_byte_q == apta_pkg::CH_LF)
	`APTA_ASSERT_IMPLY(a_char_range, clk, arst_n, state_q == ST_EMIT, char_q <= CHAR_LAST)
	`APTA_ASSERT_NEXT(a_mul_to_conv, clk, arst_n, state_q == ST_MUL,
		state_q == ST_CONV && cnt_q == 4'd0)

endmodule

`default_nettype wire

/* rtl/imu_angle_packet_to_ascii.sv */
// Top level: angle packet parser feeding an ASCII line formatter.
//
// Input channel (in_valid, in_stall, rx_byte) takes one received byte per transfer.
// A byte equal to the sync register restarts framing; every PACKET_LENGTH bytes a
// packet closes. A packet whose sum and type byte check out yields one line on the
// output channel (out_valid, out_stall, out_byte, last_byte): sign, three digits,
// point, three decimals, CR, LF, with last_byte set on the LF.
// Config writes (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 sync byte,
// index 1 angle type byte; cfg_ready is always high.
// Throughput: one byte per cycle while the raw-value queue has room. For each good
// packet the formatter pops the queue, multiplies, converts to BCD two bits per step
// and emits ten characters before it pops again, so the queue depth and formatter
// set how many closely spaced good packets pass without stalling input.
// The line's characters go out one per cycle while out_stall is low.
// Reset clears framing state, empties the queue and loads 0x55 / 0x53 into the
// config registers. A stalled receiver holds the output register; the formatter
// waits and the queue then fills, raising in_stall.
`default_nettype none

module imu_angle_packet_to_ascii #(
	parameter int PACKET_LENGTH = apta_pkg::PACKET_LENGTH_DEF,
	parameter int QUEUE_DEPTH   = apta_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                last_byte,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [apta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data
);

	apta_pkg::cfg_wr_t          cfg;
	apta_pkg::q_stat_t          stat;
	logic                       accept, push, pop;
	logic [apta_pkg::RAW_W-1:0] push_raw, pop_raw;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign in_stall = stat.full;
	assign accept   = in_valid && !in_stall;

	apta_parser #(
		.PACKET_LENGTH(PACKET_LENGTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_raw (push_raw)
	);

	apta_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_raw (push_raw),
		.pop      (pop),
		.pop_raw  (pop_raw),
		.stat     (stat)
	);

	apta_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.pop_raw   (pop_raw),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire
